// ===== rtl/hvn_pkg.sv =====
`timescale 1ns / 1ps
package hvn_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int DIM_W      = 11;
  localparam int POS_W      = $clog2(MAX_WIDTH);
  localparam int HGT_W      = 8;
  localparam int SCL_W      = 8;
  localparam int VEC_W      = 19;
  localparam int NRM_W      = 16;

  localparam logic [NRM_W-1:0] ONE_Q14 = 16'd16384;

  localparam logic [1:0] CFG_GRID_WIDTH     = 2'd0;
  localparam logic [1:0] CFG_GRID_HEIGHT    = 2'd1;
  localparam logic [1:0] CFG_VERTICAL_SCALE = 2'd2;

  localparam logic [DIM_W-1:0] RESET_GRID  = 11'd256;
  localparam logic [SCL_W-1:0] RESET_SCALE = 8'd64;

  typedef logic [VEC_W-1:0] comp_t;
  typedef comp_t [2:0] vec_t;
  typedef logic [NRM_W-1:0] ncomp_t;
  typedef ncomp_t [2:0] nrm_t;

  // 3x3 heights around one vertex, row major, plus the four adjacent cells
  typedef struct packed {
    logic [8:0][HGT_W-1:0] patch;
    logic [3:0]            cell_ok;
    logic [POS_W-1:0]      row;
    logic [POS_W-1:0]      col;
    logic                  last;
  } job_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input int hi);
    logic [DIM_W-1:0] r;
    r = v;
    if (v < 11'd2) r = 11'd2;
    else if (int'(v) > hi) r = DIM_W'(hi);
    return r;
  endfunction

endpackage

// ===== rtl/hvn_front.sv =====
`timescale 1ns / 1ps
module hvn_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [hvn_pkg::HGT_W-1:0]     sample_i,
  input  logic [hvn_pkg::DIM_W-1:0]     width_i,
  input  logic [hvn_pkg::DIM_W-1:0]     height_i,
  output hvn_pkg::job_t                 job_o,
  output logic                          job_push_o,
  input  logic                          job_full_i
);
  import hvn_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_RD   = 2'd1;
  localparam logic [1:0] F_EMIT = 2'd2;

  logic [HGT_W-1:0] upper_mem  [MAX_WIDTH];
  logic [HGT_W-1:0] middle_mem [MAX_WIDTH];
  logic [HGT_W-1:0] up_q, mid_q, sample_q;
  logic [HGT_W-1:0] win_q [9];
  logic [POS_W-1:0] row_q, col_q, er_q, ec_q;
  logic [3:0]       mask_q, mask_new, sel;
  logic [1:0]       state_q;
  logic             accept, last_col, last_row, both, kr, kc;
  logic [POS_W-1:0] vr, vc;

  assign full     = (state_q != F_IDLE);
  assign accept   = push && !full;
  assign last_col = {1'b0, col_q} >= width_i - 11'd1;
  assign last_row = {1'b0, row_q} >= height_i - 11'd1;
  assign both     = (row_q != '0) && (col_q != '0);
  assign mask_new = {both && last_col && last_row, both && last_row,
                     both && last_col, both};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      up_q     <= upper_mem[col_q];
      mid_q    <= middle_mem[col_q];
      sample_q <= sample_i;
    end
    if (state_q == F_RD) begin
      upper_mem[col_q]  <= mid_q;
      middle_mem[col_q] <= sample_q;
    end
  end

  // take the lowest pending vertex first
  always_comb begin
    priority if (mask_q[0]) sel = 4'b0001;
    else if (mask_q[1]) sel = 4'b0010;
    else if (mask_q[2]) sel = 4'b0100;
    else sel = 4'b1000;
  end

  assign kr = sel[2] | sel[3];
  assign kc = sel[1] | sel[3];
  assign vr = kr ? er_q : er_q - 10'd1;
  assign vc = kc ? ec_q : ec_q - 10'd1;

  always_comb begin
    int ra, cb;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        ra = a + (kr ? 1 : 0);
        cb = b + (kc ? 1 : 0);
        if (ra <= 2 && cb <= 2) job_o.patch[3*a+b] = win_q[3*ra+cb];
        else job_o.patch[3*a+b] = '0;
      end
    end
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        job_o.cell_ok[2*a+b] = !(a == 0 && vr == '0) && (int'(vr) + 1 + a <= int'(height_i))
                            && !(b == 0 && vc == '0) && (int'(vc) + 1 + b <= int'(width_i));
      end
    end
    job_o.row  = vr;
    job_o.col  = vc;
    job_o.last = (mask_q & ~sel) == 4'b0000;
  end

  assign job_push_o = (state_q == F_EMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      er_q    <= '0;
      ec_q    <= '0;
      mask_q  <= '0;
      for (int k = 0; k < 9; k++) win_q[k] <= '0;
    end else begin
      unique case (state_q)
        F_IDLE: begin
          if (accept) state_q <= F_RD;
        end
        F_RD: begin
          for (int k = 0; k < 3; k++) begin
            win_q[3*k]   <= win_q[3*k+1];
            win_q[3*k+1] <= win_q[3*k+2];
          end
          win_q[2] <= up_q;
          win_q[5] <= mid_q;
          win_q[8] <= sample_q;
          mask_q   <= mask_new;
          // hold the position of this sample while its vertices are released
          er_q     <= row_q;
          ec_q     <= col_q;
          if (last_col) begin
            col_q <= '0;
            row_q <= last_row ? '0 : row_q + 10'd1;
          end else begin
            col_q <= col_q + 10'd1;
          end
          state_q <= (mask_new != '0) ? F_EMIT : F_IDLE;
        end
        F_EMIT: begin
          if (!job_full_i) begin
            mask_q <= mask_q & ~sel;
            if ((mask_q & ~sel) == 4'b0000) state_q <= F_IDLE;
          end
        end
        default: state_q <= F_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hvn_job_fifo.sv =====
`timescale 1ns / 1ps
module hvn_job_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  hvn_pkg::job_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output hvn_pkg::job_t data_o,
  output logic          empty_o
);
  import hvn_pkg::*;

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wr_q <= ~wr_q;
      if (do_pop) rd_q <= ~rd_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/hvn_norm.sv =====
`timescale 1ns / 1ps
module hvn_norm (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  hvn_pkg::vec_t vec_i,
  output logic          busy_o,
  output logic          done_o,
  output hvn_pkg::nrm_t nrm_o
);
  import hvn_pkg::*;

  localparam logic [2:0] N_IDLE = 3'd0;
  localparam logic [2:0] N_SQ   = 3'd1;
  localparam logic [2:0] N_SQRT = 3'd2;
  localparam logic [2:0] N_DIV  = 3'd3;
  localparam logic [2:0] N_DONE = 3'd4;

  logic [2:0]  state_q;
  vec_t        v_q;
  nrm_t        o_q;
  logic [1:0]  k_q;
  logic [39:0] acc_q, r_q, bit_q, trial;
  logic [35:0] rem_q, den, dsh;
  logic [14:0] q_q, qn;
  logic [3:0]  bi_q;
  logic [37:0] sq;
  logic [18:0] cur_mag;

  function automatic logic [18:0] mag(input comp_t c);
    return c[VEC_W-1] ? 19'(-c) : 19'(c);
  endfunction

  function automatic logic [35:0] load(input comp_t c, input logic [39:0] len);
    return (36'(mag(c)) << 15) + 36'(len[20:0]);
  endfunction

  assign cur_mag = mag(v_q[k_q]);
  assign sq      = 38'(cur_mag) * 38'(cur_mag);
  assign trial   = r_q + bit_q;
  assign den     = 36'(r_q[20:0]) << 1;
  assign dsh     = den << bi_q;
  assign qn      = (rem_q >= dsh) ? (q_q | (15'd1 << bi_q)) : q_q;
  assign busy_o  = (state_q != N_IDLE);
  assign done_o  = (state_q == N_DONE);
  assign nrm_o   = o_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        N_IDLE: begin
          if (start_i) begin
            v_q     <= vec_i;
            acc_q   <= '0;
            k_q     <= '0;
            state_q <= N_SQ;
          end
        end
        N_SQ: begin
          acc_q <= acc_q + 40'(sq);
          if (k_q == 2'd2) begin
            k_q     <= '0;
            r_q     <= '0;
            bit_q   <= 40'd1 << 38;
            state_q <= N_SQRT;
          end else begin
            k_q <= k_q + 2'd1;
          end
        end
        N_SQRT: begin
          if (bit_q == '0) begin
            if (r_q == '0) begin
              o_q     <= {ncomp_t'(0), ONE_Q14, ncomp_t'(0)};
              state_q <= N_DONE;
            end else begin
              rem_q   <= load(v_q[0], r_q);
              q_q     <= '0;
              bi_q    <= 4'd14;
              k_q     <= '0;
              state_q <= N_DIV;
            end
          end else begin
            if (acc_q >= trial) begin
              acc_q <= acc_q - trial;
              r_q   <= (r_q >> 1) + bit_q;
            end else begin
              r_q <= r_q >> 1;
            end
            bit_q <= bit_q >> 2;
          end
        end
        N_DIV: begin
          if (rem_q >= dsh) rem_q <= rem_q - dsh;
          if (bi_q == '0) begin
            o_q[k_q] <= v_q[k_q][VEC_W-1] ? -ncomp_t'(qn) : ncomp_t'(qn);
            if (k_q == 2'd2) begin
              state_q <= N_DONE;
            end else begin
              k_q   <= k_q + 2'd1;
              rem_q <= load(v_q[k_q + 2'd1], r_q);
              q_q   <= '0;
              bi_q  <= 4'd14;
            end
          end else begin
            q_q  <= qn;
            bi_q <= bi_q - 4'd1;
          end
        end
        N_DONE: state_q <= N_IDLE;
        default: state_q <= N_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/hvn_back.sv =====
`timescale 1ns / 1ps
module hvn_back (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  hvn_pkg::job_t             job_i,
  input  logic                      job_empty_i,
  output logic                      job_pop_o,
  input  logic [hvn_pkg::SCL_W-1:0] scale_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [hvn_pkg::POS_W-1:0] vertex_row_o,
  output logic [hvn_pkg::POS_W-1:0] vertex_column_o,
  output logic signed [15:0]        normal_x_o,
  output logic signed [15:0]        normal_y_o,
  output logic signed [15:0]        normal_z_o,
  output logic                      last_of_run_o
);
  import hvn_pkg::*;

  localparam logic [1:0] B_IDLE  = 2'd0;
  localparam logic [1:0] B_TRI   = 2'd1;
  localparam logic [1:0] B_TWAIT = 2'd2;
  localparam logic [1:0] B_SWAIT = 2'd3;

  logic [1:0]        state_q;
  job_t              job_q;
  logic [3:0]        tri_q;
  vec_t              sum_q, tri_vec, norm_vec;
  nrm_t              nrm;
  logic              out_valid_q, norm_start, norm_busy, norm_done, applies;
  logic [HGT_W-1:0]  h00, h01, h10, h11;
  logic signed [8:0] da, db;
  logic signed [17:0] px, pz;

  function automatic logic [HGT_W-1:0] pix(input job_t j, input int ra, input int cb);
    return j.patch[3*ra+cb];
  endfunction

  // triangle index: cell in bits 2:1, second triangle of the cell in bit 0
  assign h00 = pix(job_q, int'(tri_q[2]), int'(tri_q[1]));
  assign h01 = pix(job_q, int'(tri_q[2]), int'(tri_q[1]) + 1);
  assign h10 = pix(job_q, int'(tri_q[2]) + 1, int'(tri_q[1]));
  assign h11 = pix(job_q, int'(tri_q[2]) + 1, int'(tri_q[1]) + 1);
  assign da  = tri_q[0] ? ($signed({1'b0, h01}) - $signed({1'b0, h11}))
                        : ($signed({1'b0, h00}) - $signed({1'b0, h10}));
  assign db  = tri_q[0] ? ($signed({1'b0, h10}) - $signed({1'b0, h11}))
                        : ($signed({1'b0, h00}) - $signed({1'b0, h01}));
  assign px  = da * $signed({1'b0, scale_i});
  assign pz  = db * $signed({1'b0, scale_i});

  assign tri_vec[0] = VEC_W'(px);
  assign tri_vec[1] = comp_t'(256);
  assign tri_vec[2] = VEC_W'(pz);

  // the corner triangles facing away from the vertex do not touch it
  assign applies    = job_q.cell_ok[tri_q[2:1]] && (tri_q != 4'd0) && (tri_q != 4'd7);
  assign norm_start = (state_q == B_TRI) && (tri_q[3] || applies);
  assign norm_vec   = tri_q[3] ? sum_q : tri_vec;
  assign job_pop_o  = (state_q == B_IDLE) && !job_empty_i && !out_valid_q;
  assign empty      = !out_valid_q;

  hvn_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (norm_start),
    .vec_i   (norm_vec),
    .busy_o  (norm_busy),
    .done_o  (norm_done),
    .nrm_o   (nrm)
  );

  always_ff @(posedge clk_i) begin
    if (state_q == B_SWAIT && norm_done) begin
      vertex_row_o    <= job_q.row;
      vertex_column_o <= job_q.col;
      normal_x_o      <= nrm[0];
      normal_y_o      <= nrm[1];
      normal_z_o      <= nrm[2];
      last_of_run_o   <= job_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      tri_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop && out_valid_q) out_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (job_pop_o) begin
            job_q   <= job_i;
            tri_q   <= '0;
            sum_q   <= '0;
            state_q <= B_TRI;
          end
        end
        B_TRI: begin
          if (tri_q[3]) state_q <= B_SWAIT;
          else if (applies) state_q <= B_TWAIT;
          else tri_q <= tri_q + 4'd1;
        end
        B_TWAIT: begin
          if (norm_done) begin
            for (int k = 0; k < 3; k++) sum_q[k] <= sum_q[k] + VEC_W'($signed(nrm[k]));
            tri_q   <= tri_q + 4'd1;
            state_q <= B_TRI;
          end
        end
        B_SWAIT: begin
          if (norm_done) begin
            out_valid_q <= 1'b1;
            state_q     <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    norm_start |-> !norm_busy) else $error("normaliser restarted while busy");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_SWAIT && norm_done) |-> !out_valid_q)
    else $error("result register overwritten");

  a_tri_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == B_TWAIT) |-> !tri_q[3]) else $error("triangle index out of range");

endmodule

// ===== rtl/heightmap_vertex_normals_unit.sv =====
`timescale 1ns / 1ps
// Heightmap vertex normals. Height bytes enter in raster order through push/full;
// for each sample the front end reads the line stores, then updates the window
// and writes back, then releases each vertex that the sample completes, holding
// while the job queue is full. A vertex normal is the normalised sum of up to
// six triangle normals; every normalisation runs in one shared iterative unit:
// squaring of the three components, twenty square-root steps and a closing step,
// then three restoring divides of fifteen quotient bits each (a zero-length sum
// gives the up vector instead). That unit sets the sustained rate; the back end
// takes one job at a time and no new one while its result register is full. A
// two-entry job queue parts the front end from the back end, and the result
// register parts the back end from the consumer. The line stores are never
// cleared; entries read before being written feed only triangles outside the
// grid. Write the size and scale registers only while the block is idle.
module heightmap_vertex_normals_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [1:0]                cfg_index_i,
  input  logic [hvn_pkg::DIM_W-1:0] cfg_data_i,
  input  logic                      push,
  output logic                      full,
  input  logic [hvn_pkg::HGT_W-1:0] height_sample_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [hvn_pkg::POS_W-1:0] vertex_row_o,
  output logic [hvn_pkg::POS_W-1:0] vertex_column_o,
  output logic signed [15:0]        normal_x_o,
  output logic signed [15:0]        normal_y_o,
  output logic signed [15:0]        normal_z_o,
  output logic                      last_of_run_o
);
  import hvn_pkg::*;

  logic [DIM_W-1:0] grid_width_q, grid_height_q, width_eff, height_eff;
  logic [SCL_W-1:0] vertical_scale_q;
  job_t             fq_in, fq_out;
  logic             fq_push, fq_full, fq_pop, fq_empty;

  // hold the registers; indexes beyond the list are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q     <= RESET_GRID;
      grid_height_q    <= RESET_GRID;
      vertical_scale_q <= RESET_SCALE;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_GRID_WIDTH:     grid_width_q     <= cfg_data_i;
        CFG_GRID_HEIGHT:    grid_height_q    <= cfg_data_i;
        CFG_VERTICAL_SCALE: vertical_scale_q <= cfg_data_i[SCL_W-1:0];
        default: ;
      endcase
    end
  end

  // clamp sizes into the supported range
  assign width_eff  = clamp_dim(grid_width_q, MAX_WIDTH);
  assign height_eff = clamp_dim(grid_height_q, MAX_HEIGHT);

  hvn_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .sample_i   (height_sample_i),
    .width_i    (width_eff),
    .height_i   (height_eff),
    .job_o      (fq_in),
    .job_push_o (fq_push),
    .job_full_i (fq_full)
  );

  hvn_job_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fq_push),
    .data_i  (fq_in),
    .full_o  (fq_full),
    .pop_i   (fq_pop),
    .data_o  (fq_out),
    .empty_o (fq_empty)
  );

  hvn_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (fq_out),
    .job_empty_i     (fq_empty),
    .job_pop_o       (fq_pop),
    .scale_i         (vertical_scale_q),
    .empty           (empty),
    .pop             (pop),
    .vertex_row_o    (vertex_row_o),
    .vertex_column_o (vertex_column_o),
    .normal_x_o      (normal_x_o),
    .normal_y_o      (normal_y_o),
    .normal_z_o      (normal_z_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule
